### rtl/rdb_pkg.sv
// Shared constants, types and helpers for the reversible deque buffer.
package rdb_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;
	localparam int PTR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int SUM_BITS  = CNT_BITS + 1;

	typedef enum logic [1:0] {
		CMD_PUSH_HEAD = 2'd0,
		CMD_PUSH_TAIL = 2'd1,
		CMD_POP_HEAD  = 2'd2,
		CMD_REVERSE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_t;

	// ring index of a sum that stays below twice the capacity
	function automatic logic [PTR_BITS-1:0] ring_wrap(input logic [SUM_BITS-1:0] s);
		logic [SUM_BITS-1:0] r;
		r = (s >= SUM_BITS'(CAPACITY)) ? (s - SUM_BITS'(CAPACITY)) : s;
		return r[PTR_BITS-1:0];
	endfunction

endpackage

### rtl/rdb_ctrl.sv
// Command sequencer: load, execute, respond.
module rdb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output rdb_pkg::ctrl_t ctl
);
	import rdb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		done     = 1'b0;
		ctl.load = 1'b0;
		ctl.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/rdb_dp.sv
// Datapath: ring store, front pointer, count, orientation and result registers.
module rdb_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rdb_pkg::ctrl_t                      ctl,
	input  logic [1:0]                          cmd,
	input  logic signed [rdb_pkg::WORD_BITS-1:0] value,
	output logic                                ok,
	output logic signed [rdb_pkg::WORD_BITS-1:0] removed_value,
	output logic [rdb_pkg::CNT_BITS-1:0]        count
);
	import rdb_pkg::*;

	logic [WORD_BITS-1:0] mem [CAPACITY];

	cmd_t                 cmd_q;
	logic [WORD_BITS-1:0] value_q;
	logic [PTR_BITS-1:0]  front_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 rev_q;
	logic                 ok_q;
	logic [WORD_BITS-1:0] removed_q;

	logic                full, empty, is_push, at_front, push_ok, pop_ok;
	logic [PTR_BITS-1:0] front_dec, front_inc, back_slot, last_slot, waddr, raddr;
	logic [SUM_BITS-1:0] cnt_ext;

	assign full     = (count_q == CNT_BITS'(CAPACITY));
	assign empty    = (count_q == '0);
	assign is_push  = (cmd_q == CMD_PUSH_HEAD) || (cmd_q == CMD_PUSH_TAIL);
	assign at_front = (cmd_q == CMD_PUSH_HEAD) ^ rev_q;
	assign push_ok  = is_push && !full;
	assign pop_ok   = (cmd_q == CMD_POP_HEAD) && !empty;

	assign cnt_ext   = SUM_BITS'(count_q);
	assign front_dec = (front_q == '0) ? PTR_BITS'(CAPACITY - 1) : (front_q - 1'b1);
	assign front_inc = ring_wrap(SUM_BITS'(front_q) + SUM_BITS'(1));
	assign back_slot = ring_wrap(SUM_BITS'(front_q) + cnt_ext);
	assign last_slot = ring_wrap(SUM_BITS'(front_q) + cnt_ext - SUM_BITS'(1));
	assign waddr     = at_front ? front_dec : back_slot;
	assign raddr     = rev_q ? last_slot : front_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_t'(cmd);
			value_q <= value;
		end
		if (ctl.exec && push_ok) begin
			mem[waddr] <= value_q;
		end
		if (ctl.exec) begin
			removed_q <= pop_ok ? mem[raddr] : '0;
			ok_q      <= push_ok || pop_ok || (cmd_q == CMD_REVERSE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (ctl.exec) begin
			if (push_ok) begin
				count_q <= count_q + 1'b1;
				if (at_front) begin
					front_q <= front_dec;
				end
			end else if (pop_ok) begin
				count_q <= count_q - 1'b1;
				if (!rev_q) begin
					front_q <= front_inc;
				end
			end else if (cmd_q == CMD_REVERSE) begin
				rev_q <= !rev_q;
			end
		end
	end

	assign ok            = ok_q;
	assign removed_value = removed_q;
	assign count         = count_q;

endmodule

### rtl/reversible_deque_buffer.sv
// Top level of the reversible deque buffer.
// Once start is accepted, the controller passes execute, then raises done in respond.
// A new command is taken only once the last one has passed the controller's
// load, execute and respond steps; busy is high until then.
// Reset: clears front pointer, count, orientation and controller; store is not cleared.
// Results cannot be stalled: each is valid in the one cycle done is high.
module reversible_deque_buffer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          cmd,
	input  logic signed [rdb_pkg::WORD_BITS-1:0] value,
	output logic                                done,
	output logic                                ok,
	output logic signed [rdb_pkg::WORD_BITS-1:0] removed_value,
	output logic [rdb_pkg::CNT_BITS-1:0]        count
);
	import rdb_pkg::*;

	ctrl_t ctl;

	rdb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	rdb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (cmd),
		.value         (value),
		.ok            (ok),
		.removed_value (removed_value),
		.count         (count)
	);

endmodule

### rtl/rdb_chk.sv
// Port-level checker for the reversible deque buffer, bound to the top level.
module rdb_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         ok,
	input logic [rdb_pkg::CNT_BITS-1:0] count
);
	import rdb_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transfer");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result missing two cycles after transfer");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !done)
		else $error("result strobe not single cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count <= CNT_BITS'(CAPACITY)))
		else $error("count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> $stable(count))
		else $error("refused command changed count");

endmodule

bind reversible_deque_buffer rdb_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.ok     (ok),
	.count  (count)
);

### dv/tb_reversible_deque_buffer.sv
// Self-checking testbench for the reversible deque buffer: directed and random command streams.
`timescale 1ns / 1ps

module tb_reversible_deque_buffer;
	import rdb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 700;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic                        ok;
		logic signed [WORD_BITS-1:0] removed;
		logic [CNT_BITS-1:0]         count;
	} deque_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [1:0]                  cmd;
	logic signed [WORD_BITS-1:0] value;
	logic                        done;
	logic                        ok;
	logic signed [WORD_BITS-1:0] removed_value;
	logic [CNT_BITS-1:0]         count;

	reversible_deque_buffer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.value         (value),
		.done          (done),
		.ok            (ok),
		.removed_value (removed_value),
		.count         (count)
	);

	// deque mirror
	logic signed [WORD_BITS-1:0] mirror_store [CAPACITY];
	int                          mirror_front;
	int                          mirror_count;
	logic                        mirror_reversed;

	deque_result_t pending_results[$];

	int fail_count;
	int cycle_count;
	int transfers;
	int refused_pushes;
	int refused_pops;
	int reversals;
	int peak_count;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("reversible_deque_buffer regression: fail");
			$finish;
		end
	end

	function automatic deque_result_t apply_command(input cmd_t c,
			input logic signed [WORD_BITS-1:0] v);
		deque_result_t r;
		r = '0;
		case (c)
			CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
				if (mirror_count < CAPACITY) begin
					if ((c == CMD_PUSH_HEAD) != mirror_reversed) begin
						mirror_front = (mirror_front + CAPACITY - 1) % CAPACITY;
						mirror_store[mirror_front] = v;
					end else begin
						mirror_store[(mirror_front + mirror_count) % CAPACITY] = v;
					end
					mirror_count++;
					r.ok = 1'b1;
				end
			end
			CMD_POP_HEAD: begin
				if (mirror_count > 0) begin
					if (!mirror_reversed) begin
						r.removed = mirror_store[mirror_front];
						mirror_front = (mirror_front + 1) % CAPACITY;
					end else begin
						r.removed = mirror_store[(mirror_front + mirror_count - 1) % CAPACITY];
					end
					mirror_count--;
					r.ok = 1'b1;
				end
			end
			CMD_REVERSE: begin
				mirror_reversed = !mirror_reversed;
				r.ok = 1'b1;
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		r.count = mirror_count[CNT_BITS-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		deque_result_t want;
		deque_result_t got;
		if (arst_n && done) begin
			got = '{ok: ok, removed: removed_value, count: count};
			if (pending_results.size() == 0) begin
				if (fail_count < 10)
					$display("%0t: result with nothing pending: ok %0b removed %0d count %0d",
						$time, got.ok, got.removed, got.count);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.ok !== want.ok || got.removed !== want.removed
						|| got.count !== want.count) begin
					if (fail_count < 10)
						$display("%0t: mismatch ok %0b/%0b removed %0d/%0d count %0d/%0d (exp/act)",
							$time, want.ok, got.ok, want.removed, got.removed,
							want.count, got.count);
					fail_count++;
				end
			end
		end
	end

	// one transfer; called and returns at a falling edge
	task automatic send_cmd(input cmd_t c, input logic signed [WORD_BITS-1:0] v);
		deque_result_t r;
		cmd   = c;
		value = v;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		r = apply_command(c, v);
		pending_results.push_back(r);
		transfers++;
		if (!r.ok && c == CMD_POP_HEAD)
			refused_pops++;
		else if (!r.ok)
			refused_pushes++;
		if (c == CMD_REVERSE)
			reversals++;
		if (mirror_count > peak_count)
			peak_count = mirror_count;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic random_pause();
		int roll;
		int n;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			n = 0;
		else if (roll < 90)
			n = $urandom_range(1, 3);
		else if (roll < 97)
			n = $urandom_range(4, 10);
		else
			n = $urandom_range(20, 60);
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_for_results();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [WORD_BITS-1:0] random_word();
		logic signed [WORD_BITS-1:0] w;
		case ($urandom_range(0, 19))
			0: w = {1'b1, {(WORD_BITS-1){1'b0}}};
			1: w = {1'b0, {(WORD_BITS-1){1'b1}}};
			2: w = '0;
			3: w = '1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic cmd_t pick_cmd(input int mode);
		int roll;
		int ph;
		int pt;
		int pp;
		roll = $urandom_range(0, 99);
		case (mode)
			0: begin ph = 38; pt = 37; pp = 15; end
			1: begin ph = 8;  pt = 7;  pp = 75; end
			2: begin ph = 25; pt = 25; pp = 35; end
			default: begin ph = 20; pt = 20; pp = 30; end
		endcase
		if (roll < ph)
			return CMD_PUSH_HEAD;
		if (roll < ph + pt)
			return CMD_PUSH_TAIL;
		if (roll < ph + pt + pp)
			return CMD_POP_HEAD;
		return CMD_REVERSE;
	endfunction

	task automatic test_empty_queue();
		send_cmd(CMD_POP_HEAD, 32'sd12345);
		send_cmd(CMD_REVERSE, '1);
	endtask

	task automatic test_extreme_words();
		send_cmd(CMD_PUSH_HEAD, {1'b0, {(WORD_BITS-1){1'b1}}});
		send_cmd(CMD_PUSH_TAIL, {1'b1, {(WORD_BITS-1){1'b0}}});
		send_cmd(CMD_REVERSE, '0);
		send_cmd(CMD_POP_HEAD, '1);
		send_cmd(CMD_POP_HEAD, '0);
		send_cmd(CMD_POP_HEAD, '0);
	endtask

	task automatic test_full_queue();
		int i;
		for (i = 0; i < CAPACITY; i++)
			send_cmd(i[0] ? CMD_PUSH_TAIL : CMD_PUSH_HEAD, random_word());
		send_cmd(CMD_PUSH_HEAD, '1);
		send_cmd(CMD_PUSH_TAIL, '0);
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		int sent;
		int burst;
		int mode;
		bit quiet;
		bit held;
		sent = 0;
		held = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(10, 50);
			mode  = $urandom_range(0, 3);
			quiet = ($urandom_range(0, 3) == 0);
			repeat (burst) begin
				send_cmd(pick_cmd(mode), random_word());
				sent++;
				if (!quiet)
					random_pause();
			end
			if (!held && sent > RANDOM_ITEMS / 2 || $urandom_range(0, 7) == 0) begin
				wait_for_results();
				held = 1;
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = CMD_PUSH_HEAD;
		value           = '0;
		cycle_count     = 0;
		fail_count      = 0;
		transfers       = 0;
		refused_pushes  = 0;
		refused_pops    = 0;
		reversals       = 0;
		peak_count      = 0;
		mirror_front    = 0;
		mirror_count    = 0;
		mirror_reversed = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_queue();
		test_extreme_words();
		test_full_queue();
		test_random_traffic();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("%0d transfers checked: %0d refused pushes, %0d refused pops, %0d reversals",
			transfers, refused_pushes, refused_pops, reversals);
		$display("peak depth %0d of %0d, %0d mismatches", peak_count, CAPACITY, fail_count);
		if (fail_count == 0)
			$display("reversible_deque_buffer regression: pass");
		else
			$display("reversible_deque_buffer regression: fail");
		$finish;
	end

endmodule
